// ----- src/phc_pkg.sv -----
// Shared types, codes and constants of the packet header classifier.
// Used by the parser, the job queue, the counter back end and the top level.
// No dependencies.
`default_nettype none

package phc_pkg;

    // Frame layout.
    localparam logic [15:0] ETH_BYTES        = 16'd14;
    localparam logic [15:0] DHCP_FIXED_BYTES = 16'd236;

    // Ethertypes.
    localparam logic [15:0] ETH_ARP  = 16'h0806;
    localparam logic [15:0] ETH_IPV4 = 16'h0800;
    localparam logic [15:0] ETH_IPX  = 16'h8137;
    localparam logic [15:0] ETH_IPV6 = 16'h86DD;
    localparam logic [15:0] ETH_PPP  = 16'h880B;
    localparam logic [15:0] ETH_AARP = 16'h80F3;

    // IP protocol numbers.
    localparam logic [7:0] PROTO_ICMP  = 8'd1;
    localparam logic [7:0] PROTO_IGMP  = 8'd2;
    localparam logic [7:0] PROTO_IPIP  = 8'd4;
    localparam logic [7:0] PROTO_TCP   = 8'd6;
    localparam logic [7:0] PROTO_IGP   = 8'd9;
    localparam logic [7:0] PROTO_UDP   = 8'd17;
    localparam logic [7:0] PROTO_RDP   = 8'd27;
    localparam logic [7:0] PROTO_SCTP  = 8'd132;

    // Network classes.
    localparam logic [2:0] NET_ARP   = 3'd0;
    localparam logic [2:0] NET_IPV4  = 3'd1;
    localparam logic [2:0] NET_IPX   = 3'd2;
    localparam logic [2:0] NET_IPV6  = 3'd3;
    localparam logic [2:0] NET_PPP   = 3'd4;
    localparam logic [2:0] NET_AARP  = 3'd5;
    localparam logic [2:0] NET_OTHER = 3'd6;

    // Transport classes.
    localparam logic [3:0] TR_TCP   = 4'd0;
    localparam logic [3:0] TR_UDP   = 4'd1;
    localparam logic [3:0] TR_ICMP  = 4'd2;
    localparam logic [3:0] TR_IGMP  = 4'd3;
    localparam logic [3:0] TR_IPIP  = 4'd4;
    localparam logic [3:0] TR_RDP   = 4'd5;
    localparam logic [3:0] TR_SCTP  = 4'd6;
    localparam logic [3:0] TR_IGP   = 4'd7;
    localparam logic [3:0] TR_OTHER = 4'd8;
    localparam logic [3:0] TR_NONE  = 4'd9;

    // Application classes.
    localparam logic [3:0] APP_NONE    = 4'd0;
    localparam logic [3:0] APP_HTTP    = 4'd1;
    localparam logic [3:0] APP_HTTPS   = 4'd2;
    localparam logic [3:0] APP_DNS     = 4'd3;
    localparam logic [3:0] APP_DHCP    = 4'd4;
    localparam logic [3:0] APP_DHCPV6  = 4'd5;
    localparam logic [3:0] APP_FTP     = 4'd6;
    localparam logic [3:0] APP_SSH     = 4'd7;
    localparam logic [3:0] APP_TELNET  = 4'd8;
    localparam logic [3:0] APP_SMTP    = 4'd9;
    localparam logic [3:0] APP_BGP     = 4'd10;
    localparam logic [3:0] APP_IPX     = 4'd11;
    localparam logic [3:0] APP_OTHER   = 4'd12;
    localparam logic [3:0] APP_NO_WORD = 4'd13;

    // Request kinds on the input tuser.
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_READ = 1'b1;

    // Statistics counter bank.
    localparam int          NUM_COUNTERS = 29;
    localparam logic [4:0]  CNT_TOTAL    = 5'd28;
    localparam logic [4:0]  CNT_TR_BASE  = 5'd7;
    localparam logic [4:0]  CNT_APP_BASE = 5'd15;

    // Job queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = 2;

    // Recognised HTTP method and version words, right-aligned, with lengths.
    localparam int NUM_WORDS = 11;
    localparam logic [55:0] WORD_VAL [NUM_WORDS] = '{
        56'h474554,          // GET
        56'h504F5354,        // POST
        56'h48454144,        // HEAD
        56'h505554,          // PUT
        56'h44454C455445,    // DELETE
        56'h5452414345,      // TRACE
        56'h4F5054494F4E53,  // OPTIONS
        56'h434F4E4E454354,  // CONNECT
        56'h5041544348,      // PATCH
        56'h48545450,        // HTTP
        56'h68747470         // http
    };
    localparam logic [2:0] WORD_LEN [NUM_WORDS] = '{
        3'd3, 3'd4, 3'd4, 3'd3, 3'd6, 3'd5, 3'd7, 3'd7, 3'd5, 3'd4, 3'd4
    };

    // One unit of work for the back end: a finished frame or a counter read.
    typedef struct packed {
        logic        is_read;
        logic [4:0]  idx;
        logic [2:0]  net;
        logic [3:0]  tr;
        logic [3:0]  app;
        logic [15:0] off;
        logic        trunc;
    } t_job;

    // True when the first n payload bytes (n up to 7) begin with a known word.
    function automatic logic method_match(input logic [55:0] win, input logic [2:0] n);
        logic        hit;
        logic [55:0] sh;
        logic [55:0] mask;
        hit = 1'b0;
        for (int w = 0; w < NUM_WORDS; w++) begin
            if (WORD_LEN[w] <= n) begin
                sh   = win >> (6'(n - WORD_LEN[w]) * 6'd8);
                mask = (56'd1 << (6'(WORD_LEN[w]) * 6'd8)) - 56'd1;
                if ((sh & mask) == WORD_VAL[w]) begin
                    hit = 1'b1;
                end
            end
        end
        return hit;
    endfunction

endpackage

`default_nettype wire

// ----- src/packet_header_classifier.sv -----
// Packet header classifier top level: parser, job queue and counter back end.
// Takes one item (frame byte or counter read) per cycle, back to back, while the
// snapshot register is empty or the job queue has room. A result passes the snapshot
// register, the job queue and the output register before it is offered; the job queue
// holds 4 results so either side may stall on its own.
// Reset (synchronous, active low) clears the parse state and all counters.
`default_nettype none

module packet_header_classifier #(
    parameter int COUNT_BITS      = 32,
    parameter int MAX_FRAME_BYTES = 65536
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [15:0] s_axis_tdata,   // data_byte[7:0], counter_index[12:8], zero
    input  wire         s_axis_tlast,
    input  wire         s_axis_tuser,   // req_type
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [63:0] m_axis_tdata    // net_class, transport_class, app_class,
                                        // payload_offset, truncated, counter_value, zero
);

    logic          push;
    logic          full;
    logic          pop;
    logic          q_valid;
    phc_pkg::t_job f_job;
    phc_pkg::t_job b_job;

    phc_parser #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_req   (s_axis_tuser),
        .i_byte  (s_axis_tdata[7:0]),
        .i_last  (s_axis_tlast),
        .i_idx   (s_axis_tdata[12:8]),
        .o_push  (push),
        .o_job   (f_job),
        .i_full  (full)
    );

    phc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (f_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (b_job)
    );

    phc_back #(.COUNT_BITS(COUNT_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_job   (b_job),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata)
    );

endmodule

`default_nettype wire

// ----- src/phc_parser.sv -----
// Front end: parses frame bytes as they arrive, snapshots the header state at
// the last byte, classifies the frame and pushes a job. Counter reads pass as jobs.
// Depends on phc_pkg.
`default_nettype none

module phc_parser #(
    parameter int MAX_FRAME_BYTES = 65536
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_ready,
    input  wire               i_req,
    input  wire  [7:0]        i_byte,
    input  wire               i_last,
    input  wire  [4:0]        i_idx,
    output logic              o_push,
    output phc_pkg::t_job     o_job,
    input  wire               i_full
);

    localparam logic [15:0] POS_LIMIT = 16'(MAX_FRAME_BYTES - 1);

    // Per-frame parse state.
    logic [15:0] r_pos, n_pos;
    logic [15:0] r_eth, n_eth;
    logic [5:0]  r_ihl, n_ihl;
    logic [7:0]  r_proto, n_proto;
    logic [7:0]  r_te, n_te;
    logic [15:0] r_sport, n_sport;
    logic [15:0] r_dport, n_dport;
    logic [55:0] r_win, n_win;
    logic [31:0] r_tail, n_tail;
    logic        r_fnd_v, n_fnd_v;
    logic [15:0] r_fnd, n_fnd;
    logic [7:0]  r_dhcp, n_dhcp;

    // Snapshot of a finished frame or a read request.
    logic        r_s_v;
    logic        r_s_read;
    logic [4:0]  r_s_idx;
    logic [15:0] r_s_len;
    logic [15:0] r_s_eth;
    logic [5:0]  r_s_ihl;
    logic [7:0]  r_s_proto;
    logic [7:0]  r_s_te;
    logic [15:0] r_s_sport;
    logic [15:0] r_s_dport;
    logic [55:0] r_s_win;
    logic        r_s_fnd_v;
    logic [15:0] r_s_fnd;
    logic [7:0]  r_s_dhcp;

    logic        acc;
    logic        byte_acc;
    logic        finish;
    logic [6:0]  t_end;
    logic [15:0] d;
    logic [15:0] q;
    logic [3:0]  ihl_raw;
    logic [3:0]  doff;
    logic [31:0] tail_new;

    assign o_ready  = !r_s_v || !i_full;
    assign acc      = i_valid && o_ready;
    assign byte_acc = acc && (i_req == phc_pkg::REQ_BYTE);
    assign finish   = acc && ((i_req == phc_pkg::REQ_READ) || i_last);
    assign o_push   = r_s_v && !i_full;

    // Byte parser: next values of the header state.
    always_comb begin
        n_pos = r_pos; n_eth = r_eth; n_ihl = r_ihl; n_proto = r_proto; n_te = r_te;
        n_sport = r_sport; n_dport = r_dport; n_win = r_win; n_tail = r_tail;
        n_fnd_v = r_fnd_v; n_fnd = r_fnd; n_dhcp = r_dhcp;
        t_end    = 7'd14 + 7'(r_ihl);
        d        = r_pos - 16'(t_end);
        q        = r_pos - 16'(r_te);
        ihl_raw  = i_byte[3:0];
        doff     = i_byte[7:4];
        tail_new = {r_tail[23:0], i_byte};
        if (byte_acc && (r_pos < POS_LIMIT)) begin
            n_pos = r_pos + 16'd1;
            if (r_pos == 16'd12) begin
                n_eth[15:8] = i_byte;
            end
            if (r_pos == 16'd13) begin
                n_eth[7:0] = i_byte;
            end
            if ((r_eth == phc_pkg::ETH_IPV4) && (r_pos >= phc_pkg::ETH_BYTES)) begin
                if (r_pos == 16'd14) begin
                    n_ihl = (ihl_raw < 4'd5) ? 6'd20 : {ihl_raw, 2'b00};
                end
                if (r_pos == 16'd23) begin
                    n_proto = i_byte;
                    if (i_byte == phc_pkg::PROTO_TCP) begin
                        n_te = 8'(t_end) + 8'd20;
                    end else if (i_byte == phc_pkg::PROTO_UDP) begin
                        n_te = 8'(t_end) + 8'd8;
                    end else begin
                        n_te = 8'(t_end);
                    end
                end
                if ((r_pos >= 16'd24) && (r_pos >= 16'(t_end)) &&
                    ((r_proto == phc_pkg::PROTO_TCP) || (r_proto == phc_pkg::PROTO_UDP))) begin
                    if (d == 16'd0) n_sport[15:8] = i_byte;
                    if (d == 16'd1) n_sport[7:0]  = i_byte;
                    if (d == 16'd2) n_dport[15:8] = i_byte;
                    if (d == 16'd3) n_dport[7:0]  = i_byte;
                    if ((r_proto == phc_pkg::PROTO_TCP) && (d == 16'd12)) begin
                        n_te = 8'(t_end) + ((doff < 4'd5) ? 8'd20 : {2'b00, doff, 2'b00});
                    end
                    // Payload bytes: method window, DHCP op and end-of-header search.
                    if (r_pos >= 16'(r_te)) begin
                        if (q < 16'd7) begin
                            n_win = {r_win[47:0], i_byte};
                        end
                        if (q == 16'd0) begin
                            n_dhcp = i_byte;
                        end
                        n_tail = tail_new;
                        if ((q >= 16'd3) && (tail_new == 32'h0D0A0D0A) && !r_fnd_v) begin
                            n_fnd_v = 1'b1;
                            n_fnd   = r_pos + 16'd1;
                        end
                    end
                end
            end
        end
    end

    // Parse state registers; cleared at the end of each frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (byte_acc && i_last)) begin
            r_pos <= '0; r_eth <= '0; r_ihl <= '0; r_proto <= '0; r_te <= '0;
            r_sport <= '0; r_dport <= '0; r_win <= '0; r_tail <= '0;
            r_fnd_v <= 1'b0; r_fnd <= '0; r_dhcp <= '0;
        end else begin
            r_pos <= n_pos; r_eth <= n_eth; r_ihl <= n_ihl; r_proto <= n_proto;
            r_te <= n_te; r_sport <= n_sport; r_dport <= n_dport; r_win <= n_win;
            r_tail <= n_tail; r_fnd_v <= n_fnd_v; r_fnd <= n_fnd; r_dhcp <= n_dhcp;
        end
    end

    // Snapshot stage valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_v <= 1'b0;
        end else if (finish) begin
            r_s_v <= 1'b1;
        end else if (o_push) begin
            r_s_v <= 1'b0;
        end
    end

    // Snapshot payload.
    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_s_read  <= (i_req == phc_pkg::REQ_READ);
            r_s_idx   <= i_idx;
            r_s_len   <= n_pos;
            r_s_eth   <= n_eth;
            r_s_ihl   <= n_ihl;
            r_s_proto <= n_proto;
            r_s_te    <= n_te;
            r_s_sport <= n_sport;
            r_s_dport <= n_dport;
            r_s_win   <= n_win;
            r_s_fnd_v <= n_fnd_v;
            r_s_fnd   <= n_fnd;
            r_s_dhcp  <= n_dhcp;
        end
    end

    logic [6:0]  c_t;
    logic [15:0] c_pl;
    logic [2:0]  c_n;

    function automatic logic port_is(input logic [15:0] s, input logic [15:0] dp,
                                     input logic [15:0] p);
        return (s == p) || (dp == p);
    endfunction

    // Classifier over the snapshot.
    always_comb begin
        o_job       = '0;
        o_job.tr    = phc_pkg::TR_NONE;
        o_job.app   = phc_pkg::APP_NONE;
        o_job.net   = phc_pkg::NET_OTHER;
        o_job.off   = r_s_len;
        c_t         = 7'd14 + 7'(r_s_ihl);
        c_pl        = r_s_len - 16'(r_s_te);
        c_n         = (c_pl > 16'd7) ? 3'd7 : c_pl[2:0];
        if (r_s_read) begin
            o_job.is_read = 1'b1;
            o_job.idx     = r_s_idx;
            o_job.tr      = '0;
            o_job.net     = '0;
            o_job.off     = '0;
        end else if (r_s_len < phc_pkg::ETH_BYTES) begin
            o_job.trunc = 1'b1;
        end else begin
            case (r_s_eth)
                phc_pkg::ETH_ARP:  o_job.net = phc_pkg::NET_ARP;
                phc_pkg::ETH_IPV4: o_job.net = phc_pkg::NET_IPV4;
                phc_pkg::ETH_IPX:  o_job.net = phc_pkg::NET_IPX;
                phc_pkg::ETH_IPV6: o_job.net = phc_pkg::NET_IPV6;
                phc_pkg::ETH_PPP:  o_job.net = phc_pkg::NET_PPP;
                phc_pkg::ETH_AARP: o_job.net = phc_pkg::NET_AARP;
                default:           o_job.net = phc_pkg::NET_OTHER;
            endcase
            o_job.off = phc_pkg::ETH_BYTES;
            if (o_job.net == phc_pkg::NET_IPV4) begin
                if (r_s_len <= 16'd23) begin
                    o_job.trunc = 1'b1;
                    o_job.off   = r_s_len;
                end else begin
                    case (r_s_proto)
                        phc_pkg::PROTO_TCP:  o_job.tr = phc_pkg::TR_TCP;
                        phc_pkg::PROTO_UDP:  o_job.tr = phc_pkg::TR_UDP;
                        phc_pkg::PROTO_ICMP: o_job.tr = phc_pkg::TR_ICMP;
                        phc_pkg::PROTO_IGMP: o_job.tr = phc_pkg::TR_IGMP;
                        phc_pkg::PROTO_IPIP: o_job.tr = phc_pkg::TR_IPIP;
                        phc_pkg::PROTO_RDP:  o_job.tr = phc_pkg::TR_RDP;
                        phc_pkg::PROTO_SCTP: o_job.tr = phc_pkg::TR_SCTP;
                        phc_pkg::PROTO_IGP:  o_job.tr = phc_pkg::TR_IGP;
                        default:             o_job.tr = phc_pkg::TR_OTHER;
                    endcase
                    if (r_s_len < 16'(c_t)) begin
                        o_job.trunc = 1'b1;
                        o_job.off   = r_s_len;
                    end else if (o_job.tr > phc_pkg::TR_UDP) begin
                        o_job.off = 16'(c_t);
                    end else if (r_s_len < 16'(r_s_te)) begin
                        o_job.trunc = 1'b1;
                        o_job.off   = r_s_len;
                    end else begin
                        o_job.off = 16'(r_s_te);
                        if (port_is(r_s_sport, r_s_dport, 16'd80)) begin
                            // HTTP needs a method word at the start of the payload.
                            if ((c_pl != 16'd0) && phc_pkg::method_match(r_s_win, c_n)) begin
                                o_job.app = phc_pkg::APP_HTTP;
                                if (r_s_fnd_v) begin
                                    o_job.off = r_s_fnd;
                                end else begin
                                    o_job.off   = r_s_len;
                                    o_job.trunc = 1'b1;
                                end
                            end else begin
                                o_job.app = phc_pkg::APP_NO_WORD;
                            end
                        end else if (((r_s_sport == 16'd68) && (r_s_dport == 16'd67)) ||
                                     ((r_s_sport == 16'd67) && (r_s_dport == 16'd68))) begin
                            o_job.app = phc_pkg::APP_DHCP;
                            if ((c_pl != 16'd0) && ((r_s_dhcp == 8'd1) || (r_s_dhcp == 8'd2))) begin
                                if (c_pl >= phc_pkg::DHCP_FIXED_BYTES) begin
                                    o_job.off = 16'(r_s_te) + phc_pkg::DHCP_FIXED_BYTES;
                                end else begin
                                    o_job.off   = r_s_len;
                                    o_job.trunc = 1'b1;
                                end
                            end
                        end else if (port_is(r_s_sport, r_s_dport, 16'd443)) begin
                            o_job.app = phc_pkg::APP_HTTPS;
                        end else if (port_is(r_s_sport, r_s_dport, 16'd546) ||
                                     port_is(r_s_sport, r_s_dport, 16'd547)) begin
                            o_job.app = phc_pkg::APP_DHCPV6;
                        end else if (port_is(r_s_sport, r_s_dport, 16'd53)) begin
                            o_job.app = phc_pkg::APP_DNS;
                        end else if (port_is(r_s_sport, r_s_dport, 16'd20) ||
                                     port_is(r_s_sport, r_s_dport, 16'd21)) begin
                            o_job.app = phc_pkg::APP_FTP;
                        end else if (port_is(r_s_sport, r_s_dport, 16'd22)) begin
                            o_job.app = phc_pkg::APP_SSH;
                        end else if (port_is(r_s_sport, r_s_dport, 16'd23)) begin
                            o_job.app = phc_pkg::APP_TELNET;
                        end else if (port_is(r_s_sport, r_s_dport, 16'd25)) begin
                            o_job.app = phc_pkg::APP_SMTP;
                        end else if (port_is(r_s_sport, r_s_dport, 16'd179)) begin
                            o_job.app = phc_pkg::APP_BGP;
                        end else if (port_is(r_s_sport, r_s_dport, 16'd213)) begin
                            o_job.app = phc_pkg::APP_IPX;
                        end else begin
                            o_job.app = phc_pkg::APP_OTHER;
                        end
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/phc_queue.sv -----
// Short job queue between the parser and the counter back end.
// Depends on phc_pkg.
`default_nettype none

module phc_queue (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_push,
    input  phc_pkg::t_job  i_job,
    output logic           o_full,
    input  wire            i_pop,
    output logic           o_valid,
    output phc_pkg::t_job  o_job
);

    phc_pkg::t_job                   r_mem [phc_pkg::QUEUE_DEPTH];
    logic [phc_pkg::QPTR_BITS-1:0]   r_wr;
    logic [phc_pkg::QPTR_BITS-1:0]   r_rd;
    logic [phc_pkg::QPTR_BITS:0]     r_cnt;

    assign o_full  = (r_cnt == (phc_pkg::QPTR_BITS+1)'(phc_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (phc_pkg::QPTR_BITS+1)'(i_push) - (phc_pkg::QPTR_BITS+1)'(i_pop);
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

`default_nettype wire

// ----- src/phc_back.sv -----
// Back end: applies finished frames to the statistics counters, serves counter
// reads and holds the result in an output register. Depends on phc_pkg.
`default_nettype none

module phc_back #(
    parameter int COUNT_BITS = 32
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_valid,
    input  phc_pkg::t_job  i_job,
    output logic           o_pop,
    output logic           o_valid,
    input  wire            i_ready,
    output logic [63:0]    o_data
);

    logic [COUNT_BITS-1:0] r_cnt [phc_pkg::NUM_COUNTERS];
    logic                  r_ov;
    logic [63:0]           r_data;
    logic [63:0]           rd_ext;
    logic [31:0]           rd_val;
    logic [4:0]            tr_idx;
    logic [4:0]            app_idx;
    logic                  tr_en;
    logic                  app_en;
    logic                  frame;

    assign o_pop   = i_valid && (!r_ov || i_ready);
    assign o_valid = r_ov;
    assign o_data  = r_data;
    assign frame   = o_pop && !i_job.is_read;
    assign tr_idx  = phc_pkg::CNT_TR_BASE + 5'(i_job.tr);
    assign app_idx = phc_pkg::CNT_APP_BASE + 5'(i_job.app);
    assign tr_en   = (i_job.tr <= phc_pkg::TR_OTHER);
    assign app_en  = (i_job.app >= phc_pkg::APP_HTTP) && (i_job.app <= phc_pkg::APP_OTHER);

    // Counter read; indexes past the bank read as zero.
    always_comb begin
        rd_ext = '0;
        if (i_job.idx < 5'(phc_pkg::NUM_COUNTERS)) begin
            rd_ext = 64'(r_cnt[i_job.idx]);
        end
        rd_val = rd_ext[31:0];
    end

    // Counter bank: the total steps on each frame, the others on its classes.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < phc_pkg::NUM_COUNTERS; i++) begin
            if (!i_rst_n) begin
                r_cnt[i] <= '0;
            end else if (frame && ((5'(i) == phc_pkg::CNT_TOTAL) ||
                                   (5'(i) == 5'(i_job.net)) ||
                                   (tr_en && (5'(i) == tr_idx)) ||
                                   (app_en && (5'(i) == app_idx)))) begin
                r_cnt[i] <= r_cnt[i] + 1'b1;
            end
        end
    end

    // Output register valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (o_pop) begin
            r_ov <= 1'b1;
        end else if (i_ready) begin
            r_ov <= 1'b0;
        end
    end

    // Output payload: net, transport, app, offset, truncated, counter value.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= {4'd0, (i_job.is_read ? rd_val : 32'd0), i_job.trunc, i_job.off,
                       i_job.app, i_job.tr, i_job.net};
        end
    end

endmodule

`default_nettype wire
